[rtl/core/spidx_pkg.sv]
// Shared constants for the spiral index to grid coordinate core.
package spidx_pkg;

	// Default width of the grid side field.
	localparam int SIDE_BITS_DEF = 15;

	// Side of a ring that a position falls on, in spiral order.
	localparam logic [1:0] CHUNK_TOP    = 2'd0;
	localparam logic [1:0] CHUNK_LEFT   = 2'd1;
	localparam logic [1:0] CHUNK_BOTTOM = 2'd2;
	localparam logic [1:0] CHUNK_RIGHT  = 2'd3;

endpackage

[rtl/core/spiral_index_to_grid_coord_core.sv]
// Top level of the square spiral position to grid line and column converter.
// Each word carries an odd grid side and a 1-based spiral position and returns the 1-based line
// and column of that position, or zeros with the valid flag low when the side is even or the
// position lies outside the grid. The core takes one word every clock cycle unless the pipe is
// full behind a held output. It has SIDE_BITS stages of the square root, which
// resolves one root bit per stage, followed by five stages that round the ring up to odd, square
// it, locate the ring side and form the coordinates. Every stage stalls only when it is full and
// the stage after it cannot move, so bubbles are squeezed out while the output is held.
module spiral_index_to_grid_coord_core #(
	parameter int SIDE_BITS = spidx_pkg::SIDE_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// Fields from bit 0: side, position, zero padding.
	input  logic [((3*SIDE_BITS+7)/8)*8-1:0]           s_tdata,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// Fields from bit 0: line, column, zero padding.
	output logic [((2*SIDE_BITS+7)/8)*8-1:0]           m_tdata,
	// Fields from bit 0: valid_res.
	output logic                                       m_tuser
);

	localparam int PB    = 2 * SIDE_BITS;
	localparam int SW    = SIDE_BITS + 1;
	localparam int OUT_W = ((2*SIDE_BITS+7)/8)*8;

	// Square root pipeline.
	logic                 q_valid;
	logic                 q_ready;
	logic [SIDE_BITS-1:0] q_root;
	logic                 q_inexact;
	logic [SIDE_BITS-1:0] q_side;
	logic [PB-1:0]        q_pos;

	spidx_sqrt #(
		.SIDE_BITS(SIDE_BITS)
	) u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_side    (s_tdata[SIDE_BITS-1:0]),
		.in_pos     (s_tdata[SIDE_BITS+PB-1:SIDE_BITS]),
		.out_valid  (q_valid),
		.out_ready  (q_ready),
		.out_root   (q_root),
		.out_inexact(q_inexact),
		.out_side   (q_side),
		.out_pos    (q_pos)
	);

	// Stage valids and the ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5  = ~v_s5 | m_tready;
	assign rdy_s4  = ~v_s4 | rdy_s5;
	assign rdy_s3  = ~v_s3 | rdy_s4;
	assign rdy_s2  = ~v_s2 | rdy_s3;
	assign rdy_s1  = ~v_s1 | rdy_s2;
	assign q_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= q_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Stage 1: ceiling root, raised to the next odd ring side.
	logic [SW-1:0]        ceil_root;
	logic [SW-1:0]        s_s1;
	logic [SIDE_BITS-1:0] side_s1;
	logic [PB-1:0]        pos_s1;

	assign ceil_root = SW'(q_root) + SW'(q_inexact);

	always_ff @(posedge clk) begin
		if (rdy_s1 && q_valid) begin
			s_s1    <= ceil_root | SW'(1);
			side_s1 <= q_side;
			pos_s1  <= q_pos;
		end
	end

	// Stage 2: square the inner ring and the grid side.
	logic [SW-1:0]        sm2;
	logic [2*SW-1:0]      inner_sq;
	logic [PB-1:0]        grid_sq;
	logic [PB-1:0]        sq_s2;
	logic [PB-1:0]        nsq_s2;
	logic [SW-1:0]        s_s2;
	logic [SW-1:0]        per_s2;
	logic [SIDE_BITS-1:0] side_s2;
	logic [PB-1:0]        pos_s2;

	assign sm2      = s_s1 - SW'(2);
	assign inner_sq = (2*SW)'(sm2) * (2*SW)'(sm2);
	assign grid_sq  = PB'(side_s1) * PB'(side_s1);

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			sq_s2   <= inner_sq[PB-1:0];
			nsq_s2  <= grid_sq;
			s_s2    <= s_s1;
			per_s2  <= s_s1 - SW'(1);
			side_s2 <= side_s1;
			pos_s2  <= pos_s1;
		end
	end

	// Stage 3: offset into the ring, range check and edge offsets.
	logic [PB-1:0]        ring_off;
	logic [SW-1:0]        gap;
	logic [SIDE_BITS-1:0] oe;
	logic                 ok_now;
	logic [PB-1:0]        off_s3;
	logic [SW-1:0]        per_s3;
	logic [SW+1:0]        per3_s3;
	logic                 ok_s3;
	logic                 center_s3;
	logic [SIDE_BITS-1:0] c_s3;
	logic [SIDE_BITS-1:0] oc_s3;
	logic [SIDE_BITS-1:0] hi_s3;
	logic [SIDE_BITS-1:0] lo_s3;

	assign ring_off = pos_s2 - sq_s2 - PB'(1);
	assign gap      = SW'(side_s2) - s_s2;
	assign oe       = gap[SW-1:1];
	assign ok_now   = side_s2[0] && (pos_s2 != '0) && (pos_s2 <= nsq_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			off_s3    <= ring_off;
			per_s3    <= per_s2;
			per3_s3   <= (SW+2)'(per_s2) + (SW+2)'({per_s2, 1'b0});
			ok_s3     <= ok_now;
			center_s3 <= (pos_s2 == PB'(1));
			c_s3      <= (side_s2 >> 1) + SIDE_BITS'(1);
			oc_s3     <= s_s2[SW-1:1];
			hi_s3     <= side_s2 - SIDE_BITS'(1) - oe;
			lo_s3     <= oe + SIDE_BITS'(2);
		end
	end

	// Stage 4: pick the ring side by three parallel subtractions.
	logic [PB:0]          d0, d1, d2, d3;
	logic [1:0]           chunk_now;
	logic [PB:0]          cpos_now;
	logic [1:0]           chunk_s4;
	logic [SIDE_BITS-1:0] cpos_s4;
	logic                 ok_s4;
	logic                 center_s4;
	logic [SIDE_BITS-1:0] c_s4;
	logic [SIDE_BITS-1:0] cpc_s4;
	logic [SIDE_BITS-1:0] cmc_s4;
	logic [SIDE_BITS-1:0] hi_s4;
	logic [SIDE_BITS-1:0] lo_s4;

	assign d0 = (PB+1)'(off_s3);
	assign d1 = d0 - (PB+1)'(per_s3);
	assign d2 = d0 - (PB+1)'({per_s3, 1'b0});
	assign d3 = d0 - (PB+1)'(per3_s3);

	always_comb begin
		if (!d3[PB]) begin
			chunk_now = spidx_pkg::CHUNK_RIGHT;
			cpos_now  = d3;
		end else if (!d2[PB]) begin
			chunk_now = spidx_pkg::CHUNK_BOTTOM;
			cpos_now  = d2;
		end else if (!d1[PB]) begin
			chunk_now = spidx_pkg::CHUNK_LEFT;
			cpos_now  = d1;
		end else begin
			chunk_now = spidx_pkg::CHUNK_TOP;
			cpos_now  = d0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			chunk_s4  <= chunk_now;
			cpos_s4   <= cpos_now[SIDE_BITS-1:0];
			ok_s4     <= ok_s3;
			center_s4 <= center_s3;
			c_s4      <= c_s3;
			cpc_s4    <= c_s3 + oc_s3;
			cmc_s4    <= c_s3 - oc_s3;
			hi_s4     <= hi_s3;
			lo_s4     <= lo_s3;
		end
	end

	// Stage 5: form line and column, zero them for an invalid word.
	logic [SIDE_BITS-1:0] down;
	logic [SIDE_BITS-1:0] up;
	logic [SIDE_BITS-1:0] line_now;
	logic [SIDE_BITS-1:0] col_now;
	logic [SIDE_BITS-1:0] line_s5;
	logic [SIDE_BITS-1:0] col_s5;
	logic                 ok_s5;

	assign down = hi_s4 - cpos_s4;
	assign up   = lo_s4 + cpos_s4;

	always_comb begin
		case (chunk_s4)
			spidx_pkg::CHUNK_TOP: begin
				line_now = cpc_s4;
				col_now  = down;
			end
			spidx_pkg::CHUNK_LEFT: begin
				line_now = down;
				col_now  = cmc_s4;
			end
			spidx_pkg::CHUNK_BOTTOM: begin
				line_now = cmc_s4;
				col_now  = up;
			end
			default: begin
				line_now = up;
				col_now  = cpc_s4;
			end
		endcase
		if (!ok_s4) begin
			line_now = '0;
			col_now  = '0;
		end else if (center_s4) begin
			line_now = c_s4;
			col_now  = c_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			line_s5 <= line_now;
			col_s5  <= col_now;
			ok_s5   <= ok_s4;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = OUT_W'({col_s5, line_s5});
	assign m_tuser  = ok_s5;

	// An invalid word reports the origin.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (line_s5 == '0) && (col_s5 == '0))
		else $error("invalid word with nonzero coordinates");

	// A valid word always lands inside the grid, so both coordinates are nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (line_s5 != '0) && (col_s5 != '0))
		else $error("valid word with a zero coordinate");

	// The input side only stalls when the whole pipe is full behind a blocked output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while the output could move");

endmodule

[rtl/core/spidx_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with side data carried along.
module spidx_sqrt #(
	parameter int SIDE_BITS = spidx_pkg::SIDE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SIDE_BITS-1:0]     in_side,
	input  logic [2*SIDE_BITS-1:0]   in_pos,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SIDE_BITS-1:0]     out_root,
	output logic                     out_inexact,
	output logic [SIDE_BITS-1:0]     out_side,
	output logic [2*SIDE_BITS-1:0]   out_pos
);

	localparam int PB = 2 * SIDE_BITS;
	localparam int RW = SIDE_BITS + 2;

	// Per-stage pipeline registers, indexed by stage.
	logic                 vld_s  [SIDE_BITS];
	logic [SIDE_BITS-1:0] root_s [SIDE_BITS];
	logic [RW-1:0]        rem_s  [SIDE_BITS];
	logic [SIDE_BITS-1:0] side_s [SIDE_BITS];
	logic [PB-1:0]        pos_s  [SIDE_BITS];
	logic                 rdy    [SIDE_BITS+1];

	assign rdy[SIDE_BITS] = out_ready;

	// Each stage brings down two radicand bits and decides one root bit.
	for (genvar k = 0; k < SIDE_BITS; k++) begin : g_stage
		logic                 prev_v;
		logic [SIDE_BITS-1:0] prev_root;
		logic [RW-1:0]        prev_rem;
		logic [SIDE_BITS-1:0] prev_side;
		logic [PB-1:0]        prev_pos;
		logic [RW:0]          cand;
		logic [RW:0]          trial;
		logic [RW:0]          diff;
		logic                 take;

		if (k == 0) begin : g_first
			assign prev_v    = in_valid;
			assign prev_root = '0;
			assign prev_rem  = '0;
			assign prev_side = in_side;
			assign prev_pos  = in_pos;
		end else begin : g_next
			assign prev_v    = vld_s[k-1];
			assign prev_root = root_s[k-1];
			assign prev_rem  = rem_s[k-1];
			assign prev_side = side_s[k-1];
			assign prev_pos  = pos_s[k-1];
		end

		assign cand  = {prev_rem[RW-2:0], prev_pos[2*(SIDE_BITS-1-k)+1 -: 2]};
		assign trial = {1'b0, prev_root, 2'b01};
		assign diff  = cand - trial;
		assign take  = (cand >= trial);

		assign rdy[k] = ~vld_s[k] | rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_v) begin
				root_s[k] <= {prev_root[SIDE_BITS-2:0], take};
				rem_s[k]  <= take ? diff[RW-1:0] : cand[RW-1:0];
				side_s[k] <= prev_side;
				pos_s[k]  <= prev_pos;
			end
		end
	end

	assign in_ready    = rdy[0];
	assign out_valid   = vld_s[SIDE_BITS-1];
	assign out_root    = root_s[SIDE_BITS-1];
	assign out_inexact = |rem_s[SIDE_BITS-1];
	assign out_side    = side_s[SIDE_BITS-1];
	assign out_pos     = pos_s[SIDE_BITS-1];

endmodule

[tb/spiral_index_to_grid_coord_checker.sv]
// Checker that predicts and compares every result word of the spiral coordinate core.
`timescale 1ns / 100ps

module spiral_index_to_grid_coord_checker #(
	parameter int SIDE_BITS = spidx_pkg::SIDE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	// Fields from bit 0: side, position, zero padding.
	input  logic [((3*SIDE_BITS+7)/8)*8-1:0]     s_tdata,
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Fields from bit 0: line, column, zero padding.
	input  logic [((2*SIDE_BITS+7)/8)*8-1:0]     m_tdata,
	// Fields from bit 0: valid_res.
	input  logic                                 m_tuser,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   results_seen,
	output int                                   in_grid_seen
);

	localparam int SB = SIDE_BITS;
	localparam int PB = 2 * SIDE_BITS;

	// One grid coordinate as the core should report it.
	typedef struct packed {
		logic [SB-1:0] line;
		logic [SB-1:0] column;
		logic          in_grid;
	} grid_coord_t;

	grid_coord_t coord_q[$];

	// Maps a spiral position on a grid of the given side to its line and column.
	function automatic grid_coord_t grid_coord_of(input logic [SB-1:0] side,
		input logic [PB-1:0] position);
		longint unsigned n, p, c, root, trial, ring, first, per, offs, cpos, oc, oe;
		logic [1:0] quadrant;
		int b;
		grid_coord_t res;
		n = side;
		p = position;
		res = '0;
		if (side[0] && p != 0 && p <= n * n) begin
			c = n / 2 + 1;
			res.in_grid = 1'b1;
			if (p == 1) begin
				res.line = SB'(c);
				res.column = SB'(c);
			end else begin
				// Exact ceiling square root, one bit at a time from the top.
				root = 0;
				for (b = SB; b >= 0; b--) begin
					trial = root | (64'd1 << b);
					if (trial * trial <= p)
						root = trial;
				end
				if (root * root < p)
					root = root + 1;
				// The ring side is that root raised to the next odd value.
				ring = root | 64'd1;
				first = (ring - 2) * (ring - 2) + 1;
				per = ring - 1;
				offs = p - first;
				quadrant = 2'(offs / per);
				cpos = offs % per;
				oc = ring / 2;
				oe = (n - ring) / 2;
				case (quadrant)
					spidx_pkg::CHUNK_TOP: begin
						res.line = SB'(c + oc);
						res.column = SB'(n - 1 - oe - cpos);
					end
					spidx_pkg::CHUNK_LEFT: begin
						res.line = SB'(n - 1 - oe - cpos);
						res.column = SB'(c - oc);
					end
					spidx_pkg::CHUNK_BOTTOM: begin
						res.line = SB'(c - oc);
						res.column = SB'(2 + oe + cpos);
					end
					default: begin
						res.line = SB'(2 + oe + cpos);
						res.column = SB'(c + oc);
					end
				endcase
			end
		end
		return res;
	endfunction

	// Queue a prediction for each accepted query word and check each accepted result word.
	always @(posedge clk or negedge arst_n) begin
		grid_coord_t want;
		if (!arst_n) begin
			coord_q.delete();
			fail_count = 0;
			pending = 0;
			results_seen = 0;
			in_grid_seen = 0;
		end else begin
			if (s_tvalid && s_tready)
				coord_q.push_back(grid_coord_of(s_tdata[SB-1:0], s_tdata[SB +: PB]));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tuser)
					in_grid_seen++;
				if (coord_q.size() == 0) begin
					$error("result word with no query outstanding: line %0d column %0d valid_res %0d",
						m_tdata[SB-1:0], m_tdata[SB +: SB], m_tuser);
					fail_count++;
				end else begin
					want = coord_q.pop_front();
					if (m_tdata[SB-1:0] !== want.line) begin
						$error("line: expected %0d, got %0d", want.line, m_tdata[SB-1:0]);
						fail_count++;
					end
					if (m_tdata[SB +: SB] !== want.column) begin
						$error("column: expected %0d, got %0d", want.column, m_tdata[SB +: SB]);
						fail_count++;
					end
					if (m_tuser !== want.in_grid) begin
						$error("valid_res: expected %0d, got %0d", want.in_grid, m_tuser);
						fail_count++;
					end
				end
			end
			pending = coord_q.size();
		end
	end

endmodule

[tb/spiral_index_to_grid_coord_core_tb.sv]
// Testbench top for the spiral coordinate core: clock, reset, query stimulus and verdict.
`timescale 1ns / 100ps

module spiral_index_to_grid_coord_core_tb;

	localparam int SB = spidx_pkg::SIDE_BITS_DEF;
	localparam int PB = 2 * SB;
	localparam int IW = ((3*SB+7)/8)*8;
	localparam int OW = ((2*SB+7)/8)*8;
	localparam int LATENCY = SB + 5;
	localparam int PHASE_WORDS = 500;
	localparam int N_DIRECTED = 25;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [IW-1:0] s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [OW-1:0] m_tdata;
	logic          m_tuser;

	int fail_count;
	int pending;
	int results_seen;
	int in_grid_seen;
	int words_sent;
	int idle_pct;
	int stall_pct;

	always #4 clk = ~clk;

	spiral_index_to_grid_coord_core #(.SIDE_BITS(SB)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	spiral_index_to_grid_coord_checker #(.SIDE_BITS(SB)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.in_grid_seen (in_grid_seen)
	);

	// Offers one query word after a random gap and holds it until the core takes it.
	task automatic send_query(input logic [SB-1:0] side, input logic [PB-1:0] position);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IW-SB-PB){1'b0}}, position, side};
		// Ready is sampled at the falling edge, where it is settled for the coming rise.
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		words_sent++;
	endtask

	// Draws one random query: mostly positions inside an odd grid, the rest mostly malformed.
	task automatic random_query(output logic [SB-1:0] side, output logic [PB-1:0] position);
		int unsigned pick, n, ring, first, k, pos;
		pick = $urandom_range(99);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: n = 2 * $urandom_range(31) + 1;
			5, 6, 7:       n = 2 * $urandom_range(16383) + 1;
			default:       n = 32767 - 2 * $urandom_range(3);
		endcase
		if (pick < 80) begin
			if ($urandom_range(1) || n == 1) begin
				pos = $urandom_range(n * n, 1);
			end else begin
				// Land on or next to a corner of some ring inside the grid.
				ring = 2 * $urandom_range((n - 1) / 2, 1) + 1;
				first = (ring - 2) * (ring - 2) + 1;
				k = $urandom_range(4);
				pos = first + k * (ring - 1) + $urandom_range(2) - 1;
				if (pos < first)
					pos = first;
				if (pos > ring * ring)
					pos = ring * ring;
			end
		end else begin
			case ($urandom_range(3))
				0: begin
					n = $urandom_range(32767);
					pos = $urandom_range(32'h3fff_ffff);
				end
				1: begin
					n = $urandom_range(32767) & ~32'd1;
					pos = $urandom_range((n == 0) ? 1 : n * n, 1);
				end
				2: pos = n * n + 1 + $urandom_range(3);
				default: pos = 0;
			endcase
		end
		side = SB'(n);
		position = PB'(pos);
	endtask

	// Receiver side: ready drops at random according to the current stall rate.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Run ends here if the core stops answering.
	initial begin
		#5000000;
		$display("spiral_index_to_grid_coord_core_tb: FAIL");
		$finish;
	end

	// Stimulus: directed corners first, then four pacing phases of random queries.
	initial begin
		int unsigned dir_side[N_DIRECTED];
		int unsigned dir_pos[N_DIRECTED];
		logic [SB-1:0] side;
		logic [PB-1:0] position;
		int phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		words_sent = 0;
		dir_side = '{1, 1, 0, 2, 32766, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 5, 5, 5, 7,
			32767, 32767, 32767, 32767, 32767, 32767};
		dir_pos = '{1, 2, 1, 1, 5, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 0, 25, 10, 49,
			1, 1073676289, 1073676290, 32'h3fff_ffff, 32'h2000_0000, 1073545226};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_query(SB'(dir_side[i]), PB'(dir_pos[i]));

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			for (int i = 0; i < PHASE_WORDS; i++) begin
				random_query(side, position);
				send_query(side, position);
			end
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every outstanding result, then let the pipeline run empty before the verdict.
		do
			@(negedge clk);
		while (pending != 0);
		repeat (4 * LATENCY) @(posedge clk);
		@(negedge clk);

		$display("Sent %0d query words over directed cases and four pacing phases.", words_sent);
		$display("Checked %0d result words, %0d of them inside the grid.", results_seen,
			in_grid_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("spiral_index_to_grid_coord_core_tb: PASS");
		end else begin
			if (pending != 0)
				$error("%0d expected result words never arrived", pending);
			$display("spiral_index_to_grid_coord_core_tb: FAIL");
		end
		$finish;
	end

endmodule
